// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at each clock edge outside reset.
`define OLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define OLID_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define OLID_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/olid_pkg.sv =====
// Shared types and constants of the ordered list block.
`default_nettype none

package olid_pkg;

  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned ST_W = 3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_POSITION  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MATCH,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/olid_cell.sv =====
// One list cell: holds an entry and shifts it with its neighbors.
`default_nettype none

module olid_cell import olid_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic [VAL_W-1:0] left_i,
  input  wire logic [VAL_W-1:0] right_i,
  input  wire logic [VAL_W-1:0] head_i,
  input  wire logic             seen_i,
  output logic      [VAL_W-1:0] value_o,
  output logic                  seen_o
);

  localparam logic [LEN_W-1:0] Idx = LEN_W'(INDEX);

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    unique case (cmd_i.op)
      OP_MATCH: begin
        match_d = (Idx < cmd_i.len) && (entry_q == cmd_i.value);
      end
      OP_INSERT: begin
        if (Idx > LEN_W'(cmd_i.pos)) begin
          entry_d = left_i;
        end else if (Idx == LEN_W'(cmd_i.pos)) begin
          entry_d = cmd_i.value;
        end
      end
      OP_DELETE: begin
        if (seen_i || match_q) begin
          entry_d = right_i;
        end
      end
      OP_ROTATE: begin
        if (Idx + LEN_W'(1) == cmd_i.len) begin
          entry_d = head_i;
        end else if (Idx + LEN_W'(1) < cmd_i.len) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign value_o = entry_q;
  assign seen_o  = seen_i | match_q;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_insert_delete_top.sv =====
// Top level of the ordered list: command sequencer over a row of list cells.
//
//   channel  dir  tdata                          tuser            tlast
//   s_axis   in   [31:0] value, [37:32] position  [1:0] mode       -
//   m_axis   out  [31:0] item_value              [2:0] status     last
//
// Insert and delete compare every cell with the key when the command is taken,
// then, once the output register is free, shift the cells of the row at once.
// Traverse rotates the row one place per output beat, so a stalled output
// stalls the rotation.
// Reset empties the list; cell contents are not cleared.
// A new beat is taken once the previous command has handed over its last
// result to the output register.
`default_nettype none

module ordered_list_insert_delete_top import olid_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [31:0] value, [37:32] position
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // [31:0] item_value
  output logic      [2:0]  m_axis_tuser,  // [2:0] status
  output logic             m_axis_tlast
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_DELETE,
    MODE_TRAVERSE
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TRAV
  } state_e;

  state_e           state_q;
  mode_e            mode_q;
  logic [VAL_W-1:0] value_q;
  logic [POS_W-1:0] pos_q;
  logic [LW-1:0]    len_q;
  logic [CW-1:0]    cnt_q;
  logic             m_valid_q;
  logic [VAL_W-1:0] m_data_q;
  logic [ST_W-1:0]  m_user_q;
  logic             m_last_q;

  logic             s_fire;
  logic             out_free;
  logic             out_load;
  logic             ins_full;
  logic             ins_bad;
  logic             found;
  logic             trav_last;
  cell_cmd_t        cmd;

  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY:0] seen;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign ins_full      = (len_q == LW'(CAPACITY));
  assign ins_bad       = (LEN_W'(pos_q) > LEN_W'(len_q));
  assign found         = seen[CAPACITY];
  assign trav_last     = (LW'(cnt_q) + LW'(1) == len_q);
  assign seen[0]       = 1'b0;
  assign out_load      = out_free && ((state_q == S_TRAV) ||
                         (state_q == S_EXEC && (mode_q == MODE_INSERT ||
                          mode_q == MODE_DELETE ||
                          (mode_q == MODE_TRAVERSE && len_q == '0))));

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.value = value_q;
    cmd.pos   = pos_q;
    cmd.len   = LEN_W'(len_q);
    if (s_fire) begin
      cmd.op    = OP_MATCH;
      cmd.value = s_axis_tdata[VAL_W-1:0];
    end else if (state_q == S_EXEC && out_free) begin
      if (mode_q == MODE_INSERT && !ins_full && !ins_bad) begin
        cmd.op = OP_INSERT;
      end else if (mode_q == MODE_DELETE && found) begin
        cmd.op = OP_DELETE;
      end
    end else if (state_q == S_TRAV && out_free) begin
      cmd.op = OP_ROTATE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = cell_val[0];
    end else begin : g_mid
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[CAPACITY-1];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end
    olid_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left_val),
      .right_i(right_val),
      .head_i (cell_val[0]),
      .seen_i (seen[i]),
      .value_o(cell_val[i]),
      .seen_o (seen[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mode_q  <= mode_e'(s_axis_tuser);
      value_q <= s_axis_tdata[VAL_W-1:0];
      pos_q   <= s_axis_tdata[VAL_W+POS_W-1:VAL_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= ST_OK;
      m_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (mode_q)
            MODE_INSERT: begin
              if (out_free) begin
                m_data_q  <= '0;
                m_last_q  <= 1'b1;
                state_q   <= S_IDLE;
                if (ins_full) begin
                  m_user_q <= ST_FULL;
                end else if (ins_bad) begin
                  m_user_q <= ST_POSITION;
                end else begin
                  m_user_q <= ST_OK;
                  len_q    <= len_q + LW'(1);
                end
              end
            end
            MODE_DELETE: begin
              if (out_free) begin
                m_data_q  <= '0;
                m_last_q  <= 1'b1;
                state_q   <= S_IDLE;
                if (found) begin
                  m_user_q <= ST_OK;
                  len_q    <= len_q - LW'(1);
                end else begin
                  m_user_q <= ST_NOT_FOUND;
                end
              end
            end
            MODE_TRAVERSE: begin
              if (len_q == '0) begin
                if (out_free) begin
                  m_data_q  <= '0;
                  m_user_q  <= ST_EMPTY;
                  m_last_q  <= 1'b1;
                  state_q   <= S_IDLE;
                end
              end else begin
                cnt_q   <= '0;
                state_q <= S_TRAV;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_TRAV: begin
          if (out_free) begin
            m_data_q  <= cell_val[0];
            m_user_q  <= ST_OK;
            m_last_q  <= trav_last;
            cnt_q     <= cnt_q + CW'(1);
            if (trav_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/olid_chk.sv =====
// Port-level checker for the ordered list top level, with its bind.
`default_nettype none
`include "assert_macros.svh"

module olid_chk import olid_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [39:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `OLID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")
  `OLID_ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_POSITION || m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_EMPTY, "status code out of range")
  `OLID_ASSERT_IMPL(a_fail_single, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tlast && m_axis_tdata == '0, "failure beat not single or carries data")
  `OLID_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken while previous one is in flight")

endmodule

bind ordered_list_insert_delete_top olid_chk u_olid_chk (.*);

`default_nettype wire
